[src/sha1_pkg.sv]
package sha1_pkg;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // request from the front end to the compression engine
  typedef struct packed {
    logic start;
  } cmp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_sts_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = Iv0;
      3'd1: v = Iv1;
      3'd2: v = Iv2;
      3'd3: v = Iv3;
      default: v = Iv4;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    if (r < 7'd20) v = (b & c) | (~b & d);
    else if (r < 7'd40) v = b ^ c ^ d;
    else if (r < 7'd60) v = (b & c) | (b & d) | (c & d);
    else v = b ^ c ^ d;
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] v;
    if (r < 7'd20) v = K0;
    else if (r < 7'd40) v = K1;
    else if (r < 7'd60) v = K2;
    else v = K3;
    return v;
  endfunction

endpackage

[src/sha1_engine.sv]
// compression engine: schedule words sit in a 16-entry memory, one round per step.
// from round 16 on, w[r-3], w[r-8], w[r-14], w[r-16] are read in turn, then w[r] written
module sha1_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1_pkg::cmp_req_t  req_i,
  output sha1_pkg::cmp_sts_t  sts_o,
  // block buffer write port from the front end (only while idle)
  input  logic                wr_en_i,
  input  logic [3:0]          wr_addr_i,
  input  logic [31:0]         wr_data_i,
  input  logic                init_i,
  input  logic [2:0]          hrd_idx_i,
  output logic [31:0]         hrd_data_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRd0  = 3'd1;
  localparam logic [2:0] SRd1  = 3'd2;
  localparam logic [2:0] SRd2  = 3'd3;
  localparam logic [2:0] SRd3  = 3'd4;
  localparam logic [2:0] SRnd  = 3'd5;
  localparam logic [2:0] SAdd  = 3'd6;

  logic [31:0] wmem [16];
  logic [31:0] rd_q;
  logic [3:0]  raddr;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;

  logic [2:0]  state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [31:0] wnew, tmp;

  always_ff @(posedge clk_i) begin
    if (we) wmem[waddr] <= wdata;
    rd_q <= wmem[raddr];
  end

  always_comb begin
    raddr = rnd_q[3:0];
    unique case (state_q)
      SRd0: raddr = rnd_q[3:0] - 4'd3;
      SRd1: raddr = rnd_q[3:0] - 4'd8;
      SRd2: raddr = rnd_q[3:0] - 4'd14;
      default: raddr = rnd_q[3:0];
    endcase
  end

  // w for this round: acc holds xor of first three taps, rd_q has the last
  always_comb begin
    wnew = (rnd_q < 7'd16) ? rd_q : {acc_q[30:0] ^ rd_q[30:0], acc_q[31] ^ rd_q[31]};
    tmp  = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(rnd_q, b_q, c_q, d_q) + e_q +
           sha1_pkg::round_k(rnd_q) + wnew;
  end

  always_comb begin
    we    = 1'b0;
    waddr = wr_addr_i;
    wdata = wr_data_i;
    if (state_q == SIdle && wr_en_i) begin
      we = 1'b1;
    end else if (state_q == SRnd && rnd_q >= 7'd16) begin
      we    = 1'b1;
      waddr = rnd_q[3:0];
      wdata = wnew;
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    acc_d   = acc_q;
    unique case (state_q)
      SIdle: if (req_i.start) begin
        state_d = SRd3;
        rnd_d   = 7'd0;
      end
      SRd0: begin state_d = SRd1; end
      SRd1: begin acc_d = rd_q; state_d = SRd2; end
      SRd2: begin acc_d = acc_q ^ rd_q; state_d = SRd3; end
      SRd3: begin
        if (rnd_q >= 7'd16) acc_d = acc_q ^ rd_q;
        state_d = SRnd;
      end
      SRnd: begin
        rnd_d   = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = SAdd;
        else if (rnd_q >= 7'd15) state_d = SRd0;
        else state_d = SRd3;
      end
      SAdd: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // SRd3 sets up the last-tap read; the xor of tap three lands in acc before SRnd
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rnd_q   <= 7'd0;
      for (int i = 0; i < 5; i++) h_q[i] <= sha1_pkg::iv_word(3'(i));
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      if (init_i) begin
        for (int i = 0; i < 5; i++) h_q[i] <= sha1_pkg::iv_word(3'(i));
      end else if (state_q == SAdd) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (state_q == SIdle && req_i.start) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end else if (state_q == SRnd) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= tmp;
    end
  end

  assign sts_o.busy = (state_q != SIdle);
  assign sts_o.done = (state_q == SAdd);
  assign hrd_data_o = h_q[hrd_idx_i];

endmodule

[src/sha1_hash_unit.sv]
// a byte that does not fill a block is taken with no stall; a full block stalls the input
// for compression (start request; per round a read and the round step for the first 16
// words, four memory reads and the round step later; an add into the chain). final item:
// one padding byte per cycle unless a block compresses, the length as two words, one or
// two compressions, five digest transfers. reset is asynchronous and active low and
// restores the initial hash values, a zero bit count and byte position
module sha1_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        no_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] FIdle = 3'd0;
  localparam logic [2:0] FCmp  = 3'd1;
  localparam logic [2:0] FPad  = 3'd2;
  localparam logic [2:0] FLen  = 3'd3;
  localparam logic [2:0] FFin  = 3'd4;
  localparam logic [2:0] FOut  = 3'd5;

  logic [2:0]  fs_q, fs_d;
  logic [63:0] cnt_q;
  logic [5:0]  pos_q;
  logic [23:0] part_q;
  logic        fin_q;
  logic        pad_q;
  logic        lenb_q;
  logic [2:0]  oidx_q;
  logic        ovld_q;

  sha1_pkg::cmp_req_t req;
  sha1_pkg::cmp_sts_t sts;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;
  logic        init;
  logic [31:0] hdata;
  logic [7:0]  bval;
  logic        bput;
  logic        acc;

  sha1_engine u_eng (
    .clk_i, .rst_ni, .req_i(req), .sts_o(sts),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .init_i(init), .hrd_idx_i(oidx_q), .hrd_data_o(hdata)
  );

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (fs_q != FIdle);

  // one byte goes in per cycle, either from the input or from padding; none while a block compresses
  always_comb begin
    bput = 1'b0;
    bval = data_byte_i;
    if (fs_q == FIdle && acc && !no_byte_i) bput = 1'b1;
    else if (fs_q == FIdle && acc && last_byte_i) begin bput = 1'b1; bval = sha1_pkg::PadByte; end
    else if (fs_q == FPad && !pad_q) begin bput = 1'b1; bval = sha1_pkg::PadByte; end
    else if (fs_q == FPad) begin bput = 1'b1; bval = 8'h00; end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q[5:2];
    wr_data = {part_q, bval};
    req.start = 1'b0;
    if (fs_q == FLen) begin
      wr_en   = 1'b1;
      wr_addr = lenb_q ? 4'd15 : 4'd14;
      wr_data = lenb_q ? cnt_q[31:0] : cnt_q[63:32];
    end else if (bput && pos_q[1:0] == 2'd3) begin
      wr_en = 1'b1;
    end
    if ((fs_q == FCmp || fs_q == FFin) && !sts.busy) req.start = 1'b1;
  end

  assign init = (fs_q == FOut) && ovld_q && !out_stall_i && oidx_q == 3'd4;

  always_comb begin
    fs_d = fs_q;
    unique case (fs_q)
      FIdle: if (acc) begin
        if (bput && pos_q == 6'd63) fs_d = FCmp;
        else if (last_byte_i) fs_d = (no_byte_i && pos_q == 6'd55) ? FLen : FPad;
      end
      FCmp: if (sts.done) fs_d = fin_q ? FPad : FIdle;
      FPad: if (pos_q == 6'd63) fs_d = FCmp;
            else if (pos_q == 6'd55) fs_d = FLen;
      FLen: if (lenb_q) fs_d = FFin;
      FFin: if (sts.done) fs_d = FOut;
      FOut: if (init) fs_d = FIdle;
      default: fs_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= FIdle;
      cnt_q  <= '0;
      pos_q  <= '0;
      fin_q  <= 1'b0;
      pad_q  <= 1'b0;
      lenb_q <= 1'b0;
      oidx_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      fs_q <= fs_d;
      if (bput) pos_q <= pos_q + 6'd1;
      if (fs_q == FIdle && acc && !no_byte_i) cnt_q <= cnt_q + 64'd8;
      // the last item has been taken, padding follows
      if (fs_q == FIdle && acc && last_byte_i) fin_q <= 1'b1;
      // the pad byte goes in once: straight on an empty last item, else first in padding
      if ((fs_q == FIdle && acc && last_byte_i && no_byte_i) || (fs_q == FPad && !pad_q))
        pad_q <= 1'b1;
      if (fs_q == FLen) lenb_q <= !lenb_q;
      if (fs_q == FFin && sts.done) begin
        ovld_q <= 1'b1;
        oidx_q <= 3'd0;
      end else if (fs_q == FOut && ovld_q && !out_stall_i) begin
        if (oidx_q == 3'd4) begin
          ovld_q <= 1'b0;
          oidx_q <= 3'd0;
          cnt_q  <= '0;
          pos_q  <= '0;
          fin_q  <= 1'b0;
          pad_q  <= 1'b0;
        end else begin
          oidx_q <= oidx_q + 3'd1;
        end
      end
    end
  end

  // bytes of the word being built, oldest first
  always_ff @(posedge clk_i) begin
    if (bput) part_q <= {part_q[15:0], bval};
  end

  assign out_valid_o   = ovld_q;
  assign digest_word_o = hdata;
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd4);

endmodule
